// ===== hw/rtl/affine_inverse_map_warp_macros.svh =====
// ----------------------------------------------------------------------------
// Affine inverse map warp: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_INVERSE_MAP_WARP_MACROS_SVH
`define AFFINE_INVERSE_MAP_WARP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define AIMW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aimw: same-cycle check failed");

// Consequent is checked after the antecedent, delayed by the dly argument.
`define AIMW_ASSERT_AFTER(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("aimw: delayed check failed");

`endif

// ===== hw/rtl/aimw_pkg.sv =====
// ----------------------------------------------------------------------------
// aimw_pkg
// Types and constants of the affine inverse map warp.
// ----------------------------------------------------------------------------
`default_nettype none

package aimw_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int WIDTH_RESET  = 512;
  localparam int HEIGHT_RESET = 512;

  localparam int COEF_W    = 32;
  localparam int DIM_W     = 10;
  localparam int COORD_W   = 9;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_M00,
    REG_M01,
    REG_M02,
    REG_M10,
    REG_M11,
    REG_M12,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             inside_res;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/affine_inverse_map_warp.sv =====
// ----------------------------------------------------------------------------
// affine_inverse_map_warp
// Nearest-neighbor affine warp by inverse mapping over an on-chip frame store.
// ----------------------------------------------------------------------------
// Takes one item per clock while busy is low. A store item writes a pixel into
// the frame store; a request item returns one result on out_strobe after it
// is accepted, in order, and results cannot be held off by the receiver.
// Items pass through the six-stage pipe: coefficient multiply, sum, rounding,
// bounds check and address, frame store read, output register. The single
// frame store port sees one access per item, stores and reads in item order.
// busy is high only during reset and for the cycle after it. The frame store
// is not cleared; request only pixels that were stored. Write configuration
// only while no item is in flight.
`default_nettype none

`include "affine_inverse_map_warp_macros.svh"

module affine_inverse_map_warp #(
  parameter int MAX_WIDTH  = aimw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = aimw_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = aimw_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  aimw_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output aimw_pkg::out_item_t                 out_item,
  input  wire                                 cfg_we,
  input  wire  [aimw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [aimw_pkg::COEF_W-1:0]         cfg_wdata
);

  localparam int COEF_W  = aimw_pkg::COEF_W;
  localparam int DIM_W   = aimw_pkg::DIM_W;
  localparam int COORD_W = aimw_pkg::COORD_W;
  localparam int PIX_W   = aimw_pkg::PIX_W;
  localparam int PROD_W  = COEF_W + COORD_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int ABS_W   = SUM_W + 1;
  localparam int QW      = ABS_W - FRAC_BITS;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int MAXD    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LIM_W   = ($clog2(MAXD + 1) > DIM_W) ? $clog2(MAXD + 1) : DIM_W;
  localparam int LAT     = 6;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;
  localparam logic [ABS_W-1:0] HALF    = ABS_W'(1) << (FRAC_BITS - 1);
  localparam logic [ABS_W-1:0] HALF_P1 = HALF + ABS_W'(1);
  localparam logic [LIM_W-1:0] W_MAX   = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0] H_MAX   = LIM_W'(MAX_HEIGHT);

  typedef struct packed {
    logic               cmd;
    logic               keep;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pixel;
    logic signed [PROD_W-1:0] p00;
    logic signed [PROD_W-1:0] p01;
    logic signed [PROD_W-1:0] p10;
    logic signed [PROD_W-1:0] p11;
  } s1_t;

  typedef struct packed {
    logic               cmd;
    logic               keep;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pixel;
    logic signed [SUM_W-1:0] su;
    logic signed [SUM_W-1:0] sv;
  } s2_t;

  typedef struct packed {
    logic          neg;
    logic [QW-1:0] q;
  } axis_t;

  typedef struct packed {
    logic               cmd;
    logic               keep;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pixel;
    axis_t              au;
    axis_t              av;
  } s3_t;

  typedef struct packed {
    logic             req;
    logic             we;
    logic             hit;
    logic [AW-1:0]    addr;
    logic [PIX_W-1:0] pixel;
  } s4_t;

  // Round half away from zero: magnitude plus half, shifted; sign kept apart.
  function automatic axis_t round_axis(input logic signed [SUM_W-1:0] s);
    logic signed [ABS_W-1:0] se;
    logic [ABS_W-1:0]        t;
    axis_t                   r;
    se    = ABS_W'(s);
    r.neg = s[SUM_W-1];
    t     = r.neg ? (~se + HALF_P1) : (se + HALF);
    r.q   = t[ABS_W-1:FRAC_BITS];
    return r;
  endfunction

  logic signed [COEF_W-1:0] coef_r [6];
  logic [DIM_W-1:0]         width_r;
  logic [DIM_W-1:0]         height_r;
  logic                     busy_r;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  logic s5_inside_r;
  logic [PIX_W-1:0] rd_r;
  logic [PIX_W-1:0] mem [DEPTH];

  logic                out_strobe_r;
  aimw_pkg::out_item_t out_r;

  logic                      accept;
  logic                      acc_req;
  logic                      acc_store;
  logic signed [COORD_W:0]   xs, ys;
  logic [LIM_W-1:0]          w_lim, h_lim;
  logic                      in_u, in_v;
  logic [COL_W-1:0]          col;
  logic [ROW_W-1:0]          row;

  assign accept    = start && !busy_r;
  assign acc_req   = accept && (in_item.cmd == aimw_pkg::CMD_REQUEST);
  assign acc_store = accept && (in_item.cmd == aimw_pkg::CMD_STORE);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= COEF_ONE;
      coef_r[1] <= '0;
      coef_r[2] <= '0;
      coef_r[3] <= '0;
      coef_r[4] <= COEF_ONE;
      coef_r[5] <= '0;
      width_r   <= DIM_W'(aimw_pkg::WIDTH_RESET);
      height_r  <= DIM_W'(aimw_pkg::HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        aimw_pkg::REG_M00:          coef_r[0] <= cfg_wdata;
        aimw_pkg::REG_M01:          coef_r[1] <= cfg_wdata;
        aimw_pkg::REG_M02:          coef_r[2] <= cfg_wdata;
        aimw_pkg::REG_M10:          coef_r[3] <= cfg_wdata;
        aimw_pkg::REG_M11:          coef_r[4] <= cfg_wdata;
        aimw_pkg::REG_M12:          coef_r[5] <= cfg_wdata;
        aimw_pkg::REG_IMAGE_WIDTH:  width_r   <= cfg_wdata[DIM_W-1:0];
        aimw_pkg::REG_IMAGE_HEIGHT: height_r  <= cfg_wdata[DIM_W-1:0];
      endcase
    end
  end

  // stage 1: products
  always_comb begin
    xs           = {1'b0, in_item.x};
    ys           = {1'b0, in_item.y};
    s1_nxt.cmd   = in_item.cmd;
    s1_nxt.keep  = (32'(in_item.x) < 32'(MAX_WIDTH)) && (32'(in_item.y) < 32'(MAX_HEIGHT));
    s1_nxt.x     = in_item.x;
    s1_nxt.y     = in_item.y;
    s1_nxt.pixel = in_item.pixel;
    s1_nxt.p00   = coef_r[0] * xs;
    s1_nxt.p01   = coef_r[1] * ys;
    s1_nxt.p10   = coef_r[3] * xs;
    s1_nxt.p11   = coef_r[4] * ys;
  end

  // stage 2: sums
  always_comb begin
    s2_nxt.cmd   = s1_r.cmd;
    s2_nxt.keep  = s1_r.keep;
    s2_nxt.x     = s1_r.x;
    s2_nxt.y     = s1_r.y;
    s2_nxt.pixel = s1_r.pixel;
    s2_nxt.su    = SUM_W'(s1_r.p00) + SUM_W'(s1_r.p01) + SUM_W'(coef_r[2]);
    s2_nxt.sv    = SUM_W'(s1_r.p10) + SUM_W'(s1_r.p11) + SUM_W'(coef_r[5]);
  end

  // stage 3: rounding
  always_comb begin
    s3_nxt.cmd   = s2_r.cmd;
    s3_nxt.keep  = s2_r.keep;
    s3_nxt.x     = s2_r.x;
    s3_nxt.y     = s2_r.y;
    s3_nxt.pixel = s2_r.pixel;
    s3_nxt.au    = round_axis(s2_r.su);
    s3_nxt.av    = round_axis(s2_r.sv);
  end

  // stage 4: bounds and address; a negative axis is inside only when it rounds to 0
  always_comb begin
    w_lim = (LIM_W'(width_r) > W_MAX) ? W_MAX : LIM_W'(width_r);
    h_lim = (LIM_W'(height_r) > H_MAX) ? H_MAX : LIM_W'(height_r);
    in_u  = (s3_r.au.q < QW'(w_lim)) && (!s3_r.au.neg || (s3_r.au.q == '0));
    in_v  = (s3_r.av.q < QW'(h_lim)) && (!s3_r.av.neg || (s3_r.av.q == '0));
    if (s3_r.cmd == aimw_pkg::CMD_REQUEST) begin
      col = s3_r.au.q[COL_W-1:0];
      row = s3_r.av.q[ROW_W-1:0];
    end else begin
      col = COL_W'(s3_r.x);
      row = ROW_W'(s3_r.y);
    end
    s4_nxt.req    = (s3_r.cmd == aimw_pkg::CMD_REQUEST);
    s4_nxt.we     = (s3_r.cmd == aimw_pkg::CMD_STORE) && s3_r.keep;
    s4_nxt.hit    = in_u && in_v;
    s4_nxt.addr   = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
    s4_nxt.pixel  = s3_r.pixel;
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
      s4_vld_r     <= 1'b0;
      s5_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      s1_vld_r     <= accept;
      s2_vld_r     <= s1_vld_r;
      s3_vld_r     <= s2_vld_r;
      s4_vld_r     <= s3_vld_r;
      s5_vld_r     <= s4_vld_r && s4_r.req;
      out_strobe_r <= s5_vld_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_r                <= s1_nxt;
    s2_r                <= s2_nxt;
    s3_r                <= s3_nxt;
    s4_r                <= s4_nxt;
    s5_inside_r         <= s4_r.hit;
    out_r.inside_res    <= s5_inside_r;
    out_r.out_pixel     <= s5_inside_r ? rd_r : '0;
  end

  // stage 5: frame store, one access per item
  always_ff @(posedge clk) begin
    if (s4_vld_r) begin
      if (s4_r.we) begin
        mem[s4_r.addr] <= s4_r.pixel;
      end
      rd_r <= mem[s4_r.addr];
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  `AIMW_ASSERT_AFTER(a_req_gives_result, acc_req, LAT, out_strobe)
  `AIMW_ASSERT_AFTER(a_store_no_result, acc_store, LAT, !out_strobe)
  `AIMW_ASSERT_NOW(a_outside_zero, out_strobe && !out_item.inside_res, out_item.out_pixel == '0)
  `AIMW_ASSERT_NOW(a_no_write_on_req, s4_vld_r && s4_r.req, !s4_r.we)

endmodule

`default_nettype wire
